[rtl/core/rsk_pkg.sv]
// ----------------------------------------------------------------------------
// rsk_pkg
// Shared types and constants for the record sorter with selectable key.
// ----------------------------------------------------------------------------
`default_nettype none

package rsk_pkg;

	localparam int MAX_RECORDS = 64;
	localparam int IDX_W = $clog2(MAX_RECORDS);
	localparam int CNT_W = $clog2(MAX_RECORDS + 1);
	localparam int POS_W = 6;

	localparam int ID_HIGH_W = 64;
	localparam int ID_LOW_W = 40;
	localparam int NAME_HIGH_W = 64;
	localparam int NAME_LOW_W = 56;
	localparam int GRADE_W = 7;
	localparam int STR_BYTES = 15;
	localparam int STR_W = 8 * STR_BYTES;
	localparam int ID_PAD_W = STR_W - ID_HIGH_W - ID_LOW_W;

	localparam logic [1:0] KEY_ID = 2'd0;
	localparam logic [1:0] KEY_NAME = 2'd1;
	localparam logic [1:0] KEY_GRADE = 2'd2;

	localparam logic CFG_SORT_KEY = 1'b0;
	localparam logic CFG_DESCENDING = 1'b1;

	typedef struct packed {
		logic [ID_HIGH_W-1:0]   id_high;
		logic [ID_LOW_W-1:0]    id_low;
		logic [NAME_HIGH_W-1:0] name_high;
		logic [NAME_LOW_W-1:0]  name_low;
		logic [GRADE_W-1:0]     grade;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef struct packed {
		logic lt;
		logic gt;
	} cmp_res_t;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_INIT,
		ST_SEL_I0,
		ST_SEL_I1,
		ST_SEL_I2,
		ST_INS_I0,
		ST_INS_I1,
		ST_INS_I2,
		ST_J0,
		ST_J1,
		ST_J2,
		ST_SEL_J3,
		ST_INS_J3,
		ST_SEL_SW1,
		ST_SEL_SW2,
		ST_SEL_NEXT,
		ST_INS_PUT,
		ST_OUT_RD,
		ST_OUT_SHOW
	} state_t;

endpackage

`default_nettype wire

[rtl/core/rsk_ram.sv]
// ----------------------------------------------------------------------------
// rsk_ram
// Generic single-write, single-read RAM with registered, held read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rsk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/rsk_cmp.sv]
// ----------------------------------------------------------------------------
// rsk_cmp
// Shared key compare: strcmp-style byte compare for id/name, signed grade.
// ----------------------------------------------------------------------------
`default_nettype none

module rsk_cmp (
	input  wire logic [1:0]        key,
	input  wire rsk_pkg::rec_t     a,
	input  wire rsk_pkg::rec_t     b,
	output rsk_pkg::cmp_res_t      res
);

	logic [rsk_pkg::STR_W-1:0] sa;
	logic [rsk_pkg::STR_W-1:0] sb;
	logic                      slt;
	logic                      sgt;
	logic                      done;
	logic [7:0]                ba;
	logic [7:0]                bb;

	always_comb begin
		if (key == rsk_pkg::KEY_NAME) begin
			sa = {a.name_high, a.name_low};
			sb = {b.name_high, b.name_low};
		end else begin
			sa = {a.id_high, a.id_low, {rsk_pkg::ID_PAD_W{1'b0}}};
			sb = {b.id_high, b.id_low, {rsk_pkg::ID_PAD_W{1'b0}}};
		end
	end

	// first differing byte decides; a common zero byte ends the compare
	always_comb begin
		slt = 1'b0;
		sgt = 1'b0;
		done = 1'b0;
		ba = '0;
		bb = '0;
		for (int k = 0; k < rsk_pkg::STR_BYTES; k++) begin
			ba = sa[rsk_pkg::STR_W-1-8*k -: 8];
			bb = sb[rsk_pkg::STR_W-1-8*k -: 8];
			if (!done) begin
				if (ba != bb) begin
					done = 1'b1;
					slt = (ba < bb);
					sgt = (ba > bb);
				end else if (ba == 8'd0) begin
					done = 1'b1;
				end
			end
		end
	end

	always_comb begin
		case (key)
			rsk_pkg::KEY_GRADE: begin
				res.lt = ($signed(a.grade) < $signed(b.grade));
				res.gt = ($signed(a.grade) > $signed(b.grade));
			end
			default: begin
				res.lt = slt;
				res.gt = sgt;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/record_sorter_selectable_key.sv]
// ----------------------------------------------------------------------------
// record_sorter_selectable_key
// Loads a set of records, sorts by the configured key, streams load positions.
// ----------------------------------------------------------------------------
// Input stream (s_*): one record per transfer, one per cycle while loading.
// s_tlast closes the set; records beyond MAX_RECORDS are dropped and flagged.
// After the closing transfer s_tready stays low until the set is delivered.
// Sorting runs on one shared compare unit under a sequencer; each compare
// steps through an order RAM read, a record RAM read, the compare and an
// update, plus swap or shift writes. A set-up sweep first fills the order
// RAM; selection sorts always run the full set of compares, insertion sorts
// depend on the data. Output: each result is read, then shown until taken
// (m_tdata = load position, m_tuser = overflow, m_tlast = final result).
// A stalled receiver simply holds the current result; nothing is lost.
// Configuration (cfg_*) is sampled when a set closes. Reset clears the record
// count, the overflow flag and both registers; memory contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module record_sorter_selectable_key (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [1:0]   cfg_wdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// id_high[63:0], id_low[103:64], name_high[167:104], name_low[223:168],
	// avg_grade_tenths[230:224], zero[231]
	input  wire logic [231:0] s_tdata,
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// source_position[5:0], zero[7:6]
	output logic      [7:0]   m_tdata,
	// overflowed[0]
	output logic              m_tuser,
	output logic              m_tlast
);

	localparam int IW = rsk_pkg::IDX_W;
	localparam int CW = rsk_pkg::CNT_W;

	rsk_pkg::state_t state_q, state_d;

	logic [CW-1:0]    cnt_q;
	logic             ovf_q;
	logic [CW-1:0]    n_q;
	logic [1:0]       sort_key_q;
	logic             desc_cfg_q;
	logic [1:0]       key_q;
	logic             desc_q;
	logic [IW-1:0]    i_q, j_q, k_q, slot_q, r_q;
	logic [IW-1:0]    pos_i_q, pos_k_q, pos_j_q;
	rsk_pkg::rec_t    rec_k_q;
	rsk_pkg::cmp_res_t cmp_q;
	rsk_pkg::cmp_res_t cmp_res;

	logic             rec_we, rec_re;
	logic [IW-1:0]    rec_waddr, rec_raddr;
	rsk_pkg::rec_t    rec_wdata, rec_rdata;
	logic             ord_we, ord_re;
	logic [IW-1:0]    ord_waddr, ord_raddr, ord_wdata, ord_rdata;

	logic s_xfer, m_xfer, store_ok;
	logic ins_mode, sel_down, want_gt, rev_out;
	logic sel_upd, sel_last, n_small, out_last;
	logic [IW-1:0] n_m1;

	assign s_xfer = s_tvalid && s_tready;
	assign m_xfer = m_tvalid && m_tready;
	assign store_ok = (cnt_q < CW'(rsk_pkg::MAX_RECORDS));
	assign ins_mode = (key_q == rsk_pkg::KEY_NAME) ||
		((key_q == rsk_pkg::KEY_GRADE) && !desc_q);
	assign sel_down = (key_q == rsk_pkg::KEY_ID) && desc_q;
	assign want_gt = (key_q == rsk_pkg::KEY_GRADE) && desc_q;
	assign rev_out = (key_q == rsk_pkg::KEY_NAME) && desc_q;
	assign n_m1 = IW'(n_q - CW'(1));
	assign n_small = (n_q < CW'(2));
	assign sel_upd = want_gt ? cmp_q.gt : cmp_q.lt;
	assign sel_last = sel_down ? (j_q == '0) : (j_q == n_m1);
	assign out_last = (r_q == n_m1);

	assign rec_wdata.id_high = s_tdata[63:0];
	assign rec_wdata.id_low = s_tdata[103:64];
	assign rec_wdata.name_high = s_tdata[167:104];
	assign rec_wdata.name_low = s_tdata[223:168];
	assign rec_wdata.grade = s_tdata[230:224];

	rsk_ram #(.WIDTH(rsk_pkg::REC_W), .DEPTH(rsk_pkg::MAX_RECORDS)) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (rec_wdata),
		.re    (rec_re),
		.raddr (rec_raddr),
		.rdata (rec_rdata)
	);

	rsk_ram #(.WIDTH(IW), .DEPTH(rsk_pkg::MAX_RECORDS)) u_ord_ram (
		.clk   (clk),
		.we    (ord_we),
		.waddr (ord_waddr),
		.wdata (ord_wdata),
		.re    (ord_re),
		.raddr (ord_raddr),
		.rdata (ord_rdata)
	);

	rsk_cmp u_cmp (
		.key (key_q),
		.a   (rec_rdata),
		.b   (rec_k_q),
		.res (cmp_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rsk_pkg::ST_LOAD: begin
				if (s_xfer && s_tlast) begin
					state_d = rsk_pkg::ST_INIT;
				end
			end
			rsk_pkg::ST_INIT: begin
				if (i_q == n_m1) begin
					if (n_small) begin
						state_d = rsk_pkg::ST_OUT_RD;
					end else if (ins_mode) begin
						state_d = rsk_pkg::ST_INS_I0;
					end else begin
						state_d = rsk_pkg::ST_SEL_I0;
					end
				end
			end
			rsk_pkg::ST_SEL_I0:  state_d = rsk_pkg::ST_SEL_I1;
			rsk_pkg::ST_SEL_I1:  state_d = rsk_pkg::ST_SEL_I2;
			rsk_pkg::ST_SEL_I2:  state_d = rsk_pkg::ST_J0;
			rsk_pkg::ST_INS_I0:  state_d = rsk_pkg::ST_INS_I1;
			rsk_pkg::ST_INS_I1:  state_d = rsk_pkg::ST_INS_I2;
			rsk_pkg::ST_INS_I2:  state_d = rsk_pkg::ST_J0;
			rsk_pkg::ST_J0:      state_d = rsk_pkg::ST_J1;
			rsk_pkg::ST_J1:      state_d = rsk_pkg::ST_J2;
			rsk_pkg::ST_J2: begin
				state_d = ins_mode ? rsk_pkg::ST_INS_J3 : rsk_pkg::ST_SEL_J3;
			end
			rsk_pkg::ST_SEL_J3: begin
				state_d = sel_last ? rsk_pkg::ST_SEL_SW1 : rsk_pkg::ST_J0;
			end
			rsk_pkg::ST_SEL_SW1: begin
				state_d = (k_q != i_q) ? rsk_pkg::ST_SEL_SW2 : rsk_pkg::ST_SEL_NEXT;
			end
			rsk_pkg::ST_SEL_SW2: state_d = rsk_pkg::ST_SEL_NEXT;
			rsk_pkg::ST_SEL_NEXT: begin
				if (sel_down) begin
					state_d = (i_q > IW'(1)) ? rsk_pkg::ST_SEL_I0 : rsk_pkg::ST_OUT_RD;
				end else begin
					state_d = ((CW'(i_q) + CW'(2)) < n_q) ?
						rsk_pkg::ST_SEL_I0 : rsk_pkg::ST_OUT_RD;
				end
			end
			rsk_pkg::ST_INS_J3: begin
				if (cmp_q.gt && (j_q != '0)) begin
					state_d = rsk_pkg::ST_J0;
				end else begin
					state_d = rsk_pkg::ST_INS_PUT;
				end
			end
			rsk_pkg::ST_INS_PUT: begin
				state_d = ((CW'(i_q) + CW'(1)) < n_q) ?
					rsk_pkg::ST_INS_I0 : rsk_pkg::ST_OUT_RD;
			end
			rsk_pkg::ST_OUT_RD:  state_d = rsk_pkg::ST_OUT_SHOW;
			rsk_pkg::ST_OUT_SHOW: begin
				if (m_xfer) begin
					state_d = out_last ? rsk_pkg::ST_LOAD : rsk_pkg::ST_OUT_RD;
				end
			end
			default: state_d = rsk_pkg::ST_LOAD;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		rec_we = 1'b0;
		rec_waddr = cnt_q[IW-1:0];
		rec_re = 1'b0;
		rec_raddr = ord_rdata;
		ord_we = 1'b0;
		ord_waddr = i_q;
		ord_wdata = i_q;
		ord_re = 1'b0;
		ord_raddr = i_q;
		case (state_q)
			rsk_pkg::ST_LOAD: begin
				s_tready = 1'b1;
				rec_we = s_xfer && store_ok;
			end
			rsk_pkg::ST_INIT: begin
				ord_we = 1'b1;
			end
			rsk_pkg::ST_SEL_I0, rsk_pkg::ST_INS_I0: begin
				ord_re = 1'b1;
			end
			rsk_pkg::ST_SEL_I1, rsk_pkg::ST_INS_I1, rsk_pkg::ST_J1: begin
				rec_re = 1'b1;
			end
			rsk_pkg::ST_J0: begin
				ord_re = 1'b1;
				ord_raddr = j_q;
			end
			rsk_pkg::ST_SEL_SW1: begin
				ord_we = (k_q != i_q);
				ord_wdata = pos_k_q;
			end
			rsk_pkg::ST_SEL_SW2: begin
				ord_we = 1'b1;
				ord_waddr = k_q;
				ord_wdata = pos_i_q;
			end
			rsk_pkg::ST_INS_J3: begin
				ord_we = cmp_q.gt;
				ord_waddr = j_q + IW'(1);
				ord_wdata = pos_j_q;
			end
			rsk_pkg::ST_INS_PUT: begin
				ord_we = 1'b1;
				ord_waddr = slot_q;
				ord_wdata = pos_i_q;
			end
			rsk_pkg::ST_OUT_RD: begin
				ord_re = 1'b1;
				ord_raddr = rev_out ? (n_m1 - r_q) : r_q;
			end
			rsk_pkg::ST_OUT_SHOW: begin
				m_tvalid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign m_tdata = {2'b00, rsk_pkg::POS_W'(ord_rdata)};
	assign m_tuser = ovf_q;
	assign m_tlast = out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsk_pkg::ST_LOAD;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			sort_key_q <= rsk_pkg::KEY_ID;
			desc_cfg_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					rsk_pkg::CFG_SORT_KEY:   sort_key_q <= cfg_wdata;
					rsk_pkg::CFG_DESCENDING: desc_cfg_q <= cfg_wdata[0];
					default: begin
					end
				endcase
			end
			if (state_q == rsk_pkg::ST_LOAD && s_xfer) begin
				if (store_ok) begin
					cnt_q <= cnt_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == rsk_pkg::ST_OUT_SHOW && m_xfer && out_last) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			rsk_pkg::ST_LOAD: begin
				n_q <= store_ok ? (cnt_q + CW'(1)) : cnt_q;
				key_q <= (sort_key_q == rsk_pkg::KEY_NAME ||
					sort_key_q == rsk_pkg::KEY_GRADE) ? sort_key_q : rsk_pkg::KEY_ID;
				desc_q <= desc_cfg_q;
				i_q <= '0;
			end
			rsk_pkg::ST_INIT: begin
				r_q <= '0;
				if (i_q == n_m1) begin
					if (ins_mode) begin
						i_q <= IW'(1);
					end else if (sel_down) begin
						i_q <= n_m1;
					end else begin
						i_q <= '0;
					end
				end else begin
					i_q <= i_q + IW'(1);
				end
			end
			rsk_pkg::ST_SEL_I1, rsk_pkg::ST_INS_I1: begin
				pos_i_q <= ord_rdata;
				pos_k_q <= ord_rdata;
				k_q <= i_q;
			end
			rsk_pkg::ST_SEL_I2, rsk_pkg::ST_INS_I2: begin
				rec_k_q <= rec_rdata;
				j_q <= (ins_mode || sel_down) ? (i_q - IW'(1)) : (i_q + IW'(1));
			end
			rsk_pkg::ST_J1: begin
				pos_j_q <= ord_rdata;
			end
			rsk_pkg::ST_J2: begin
				cmp_q <= cmp_res;
			end
			rsk_pkg::ST_SEL_J3: begin
				if (sel_upd) begin
					k_q <= j_q;
					pos_k_q <= pos_j_q;
					rec_k_q <= rec_rdata;
				end
				if (!sel_last) begin
					j_q <= sel_down ? (j_q - IW'(1)) : (j_q + IW'(1));
				end
			end
			rsk_pkg::ST_SEL_NEXT: begin
				i_q <= sel_down ? (i_q - IW'(1)) : (i_q + IW'(1));
			end
			rsk_pkg::ST_INS_J3: begin
				if (cmp_q.gt) begin
					slot_q <= '0;
					j_q <= j_q - IW'(1);
				end else begin
					slot_q <= j_q + IW'(1);
				end
			end
			rsk_pkg::ST_INS_PUT: begin
				i_q <= i_q + IW'(1);
			end
			rsk_pkg::ST_OUT_SHOW: begin
				if (m_xfer && !out_last) begin
					r_q <= r_q + IW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output active together");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(rsk_pkg::MAX_RECORDS))
		else $error("record count beyond capacity");

	a_close_set: assert property (@(posedge clk) disable iff (!arst_n)
		(s_xfer && s_tlast) |=> !s_tready)
		else $error("input still taken after set closed");

	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		(m_xfer && m_tlast) |=> (s_tready && cnt_q == '0 && !ovf_q))
		else $error("set not cleared after final result");

endmodule

`default_nettype wire

[tb/sv/record_sorter_selectable_key_chk.sv]
// ----------------------------------------------------------------------------
// record_sorter_selectable_key_chk
// Watches the record and result streams, tracks the sort registers, orders
// each closed set in software and compares every result transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none

module record_sorter_selectable_key_chk
	import rsk_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [1:0]   cfg_wdata,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [231:0] s_tdata,
	input  wire logic         s_tlast,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [7:0]   m_tdata,
	input  wire logic         m_tuser,
	input  wire logic         m_tlast,
	output int                errors,
	output int                pending
);

	typedef struct packed {
		logic [5:0] pos;
		logic       ovf;
		logic       last;
	} rank_t;

	logic [STR_W-1:0]   id_key   [MAX_RECORDS];
	logic [STR_W-1:0]   name_key [MAX_RECORDS];
	logic signed [6:0]  grade    [MAX_RECORDS];
	int                 order    [MAX_RECORDS];
	int                 loaded;
	logic               dropped;
	logic [1:0]         key_sel;
	logic               desc;
	rank_t              ranks_due[$];

	assign pending = ranks_due.size();

	// strcmp on left-aligned, zero-padded byte strings
	function automatic int str_cmp(logic [STR_W-1:0] a, logic [STR_W-1:0] b);
		logic [7:0] x, y;
		for (int k = STR_BYTES - 1; k >= 0; k--) begin
			x = a[8*k +: 8];
			y = b[8*k +: 8];
			if (x != y)
				return (x < y) ? -1 : 1;
			if (x == 0)
				return 0;
		end
		return 0;
	endfunction

	function automatic int rec_cmp(logic [1:0] key, int a, int b);
		if (key == KEY_NAME)
			return str_cmp(name_key[a], name_key[b]);
		if (key == KEY_GRADE)
			return (grade[a] < grade[b]) ? -1 : (grade[a] > grade[b]) ? 1 : 0;
		return str_cmp(id_key[a], id_key[b]);
	endfunction

	task automatic swap_ranks(int i, int k);
		int t;
		t = order[i];
		order[i] = order[k];
		order[k] = t;
	endtask

	task automatic sort_set(int n);
		logic [1:0] key;
		int k, j, p;
		key = (key_sel == KEY_NAME || key_sel == KEY_GRADE) ? key_sel : KEY_ID;
		for (int i = 0; i < n; i++)
			order[i] = i;
		if (key == KEY_ID && !desc) begin
			for (int i = 0; i < n - 1; i++) begin
				k = i;
				for (j = i + 1; j < n; j++)
					if (rec_cmp(key, order[j], order[k]) < 0) k = j;
				if (k != i) swap_ranks(i, k);
			end
		end else if (key == KEY_ID) begin
			for (int i = n - 1; i >= 0; i--) begin
				k = i;
				for (j = i - 1; j >= 0; j--)
					if (rec_cmp(key, order[k], order[j]) > 0) k = j;
				if (k != i) swap_ranks(i, k);
			end
		end else if (key == KEY_NAME) begin
			for (int i = 1; i < n; i++) begin
				p = order[i];
				for (j = i - 1; j >= 0 && rec_cmp(key, p, order[j]) < 0; j--)
					order[j + 1] = order[j];
				order[j + 1] = p;
			end
			if (desc)
				for (int i = 0; i < n / 2; i++) swap_ranks(i, n - 1 - i);
		end else if (!desc) begin
			for (int i = n - 1; i >= 1; i--)
				for (j = 0; j < i; j++)
					if (rec_cmp(key, order[j], order[j + 1]) > 0) swap_ranks(j, j + 1);
		end else begin
			for (int i = 0; i < n - 1; i++) begin
				k = i;
				for (j = i + 1; j < n; j++)
					if (rec_cmp(key, order[k], order[j]) < 0) k = j;
				if (k != i) swap_ranks(i, k);
			end
		end
		for (int r = 0; r < n; r++)
			ranks_due.push_back('{pos: order[r][5:0], ovf: dropped, last: r == n - 1});
	endtask

	always @(posedge clk or negedge arst_n) begin
		rank_t want;
		if (!arst_n) begin
			errors = 0;
			loaded = 0;
			dropped = 0;
			key_sel = KEY_ID;
			desc = 0;
			ranks_due.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_SORT_KEY)
					key_sel = cfg_wdata;
				else
					desc = cfg_wdata[0];
			end
			if (s_tvalid && s_tready) begin
				if (loaded < MAX_RECORDS) begin
					id_key[loaded] = {s_tdata[63:0], s_tdata[103:64], {ID_PAD_W{1'b0}}};
					name_key[loaded] = {s_tdata[167:104], s_tdata[223:168]};
					grade[loaded] = s_tdata[230:224];
					loaded++;
				end else begin
					dropped = 1;
				end
				if (s_tlast) begin
					sort_set(loaded);
					loaded = 0;
					dropped = 0;
				end
			end
			if (m_tvalid && m_tready) begin
				if (ranks_due.size() == 0) begin
					$error("unexpected result transfer pos=%0d", m_tdata[5:0]);
					errors++;
				end else begin
					want = ranks_due.pop_front();
					if (m_tdata[5:0] !== want.pos) begin
						$error("source_position: expected %0d, got %0d", want.pos, m_tdata[5:0]);
						errors++;
					end
					if (m_tuser !== want.ovf) begin
						$error("overflowed: expected %0d, got %0d", want.ovf, m_tuser);
						errors++;
					end
					if (m_tlast !== want.last) begin
						$error("last_of_run: expected %0d, got %0d", want.last, m_tlast);
						errors++;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

[tb/sv/record_sorter_selectable_key_tb.sv]
// ----------------------------------------------------------------------------
// record_sorter_selectable_key_tb
// Drives record sets of varied size, content and sort settings, with random
// gaps and receiver stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module record_sorter_selectable_key_tb;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         cfg_we = 0;
	logic         cfg_index = 0;
	logic [1:0]   cfg_wdata = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [231:0] s_tdata = '0;
	logic         s_tlast = 0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [7:0]   m_tdata;
	logic         m_tuser;
	logic         m_tlast;
	int           errors;
	int           pending;
	int           cycles = 0;
	int           hold_off = 0;
	bit           stall_req = 0;
	bit           stall_taken = 0;
	bit           sending_done = 0;

	localparam int LIMIT = 4_000_000;

	always #10 clk = ~clk;

	record_sorter_selectable_key i_dut (.*);

	record_sorter_selectable_key_chk i_chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("[record_sorter_selectable_key] ERROR");
			$finish;
		end
	end

	// receiver: random wait after each transfer, plus one long hold-off
	always @(posedge clk) begin
		int gap;
		if (stall_req && !stall_taken) begin
			stall_taken <= 1;
			hold_off <= 400;
			m_tready <= 0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 0;
		end else if (m_tvalid && m_tready) begin
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				hold_off <= gap - 1;
				m_tready <= 0;
			end else begin
				m_tready <= 1;
			end
		end else begin
			m_tready <= 1;
		end
	end

	task automatic write_reg(logic idx, logic [1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	// in narrow mode, names and ids come from a small alphabet so ties and shared prefixes occur
	function automatic logic [119:0] rand_str(int nbytes, bit narrow);
		logic [119:0] s = '0;
		int len = $urandom_range(0, nbytes);
		for (int k = 0; k < len; k++)
			s[119 - 8*k -: 8] = narrow ? 8'($urandom_range(65, 67)) : 8'($urandom_range(1, 255));
		return s;
	endfunction

	// leaves s_tvalid high after the transfer; end_burst drops it
	task automatic send_record(logic [119:0] id, logic [119:0] name, logic [6:0] g, bit last);
		int gap;
		gap = $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {1'b0, g, name[55:0], name[119:56], id[55:16], id[119:56]};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic end_burst();
		s_tvalid <= 0;
		@(posedge clk);
	endtask

	task automatic send_set(int n, bit narrow);
		logic signed [6:0] g;
		for (int i = 0; i < n; i++) begin
			g = 7'($signed($urandom_range(0, 100)) - 50);
			if (narrow) g = 7'($signed($urandom_range(0, 4)) - 2);
			send_record(rand_str(13, narrow), rand_str(15, narrow), g, i == n - 1);
		end
	endtask

	initial begin
		int n;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: field extremes, each key/direction, single record
		send_record({120{1'b1}}, {120{1'b1}}, 7'sd50, 0);
		send_record('0, '0, -7'sd50, 0);
		send_record({8'h80, 112'h0}, {8'h7F, 112'h0}, 7'sd0, 1);
		end_burst();
		wait_idle();
		for (int k = 0; k < 4; k++) begin
			for (int d = 0; d < 2; d++) begin
				write_reg(rsk_pkg::CFG_SORT_KEY, 2'(k));
				write_reg(rsk_pkg::CFG_DESCENDING, 2'(d));
				send_set(2, 1);
				end_burst();
				wait_idle();
			end
		end
		send_record('1, '1, 7'h7F, 1);
		end_burst();
		wait_idle();
		// overflow: one past capacity, last record dropped; the next set is
		// offered while the receiver holds off the first set's results
		write_reg(rsk_pkg::CFG_SORT_KEY, rsk_pkg::KEY_GRADE);
		write_reg(rsk_pkg::CFG_DESCENDING, 2'd1);
		fork
			begin
				send_set(rsk_pkg::MAX_RECORDS + 1, 1);
				send_set(5, 0);
				end_burst();
			end
			begin
				@(posedge clk iff m_tvalid);
				stall_req <= 1;
			end
		join
		wait_idle();
		// random sets
		n = 0;
		while (n < 370) begin
			write_reg(rsk_pkg::CFG_SORT_KEY, 2'($urandom_range(0, 3)));
			write_reg(rsk_pkg::CFG_DESCENDING, 2'($urandom_range(0, 1)));
			if ($urandom_range(0, 9) == 0)
				send_set($urandom_range(40, 66), $urandom_range(0, 1));
			else
				send_set($urandom_range(1, 12), $urandom_range(0, 1));
			end_burst();
			wait_idle();
			n = n + 12;
		end
		sending_done = 1;
	end

	initial begin
		wait (sending_done);
		wait_idle();
		if (errors == 0)
			$display("[record_sorter_selectable_key] OK");
		else
			$display("[record_sorter_selectable_key] ERROR");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
rtl/core/rsk_pkg.sv
rtl/core/rsk_ram.sv
rtl/core/rsk_cmp.sv
rtl/core/record_sorter_selectable_key.sv
tb/sv/record_sorter_selectable_key_chk.sv
tb/sv/record_sorter_selectable_key_tb.sv
